FILE: rtl/tkri_pkg.sv
// Shared types for the top-K ranking table: item, result and control structs.
package tkri_pkg;

	// One incoming record
	typedef struct packed {
		logic signed [31:0] entry_key;
		logic [11:0]        stamp_year;
		logic [3:0]         stamp_month;
		logic [4:0]         stamp_day;
		logic [4:0]         stamp_hour;
		logic [5:0]         stamp_minute;
	} item_t;

	// One line of a table dump
	typedef struct packed {
		logic [2:0]         rank_position;
		logic signed [31:0] ranked_key;
		logic [11:0]        ranked_year;
		logic [3:0]         ranked_month;
		logic [4:0]         ranked_day;
		logic [4:0]         ranked_hour;
		logic [5:0]         ranked_minute;
		logic               input_accepted;
		logic               last_entry;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic insert;   // take the offered item and update the table
		logic emit;     // load the next entry into the result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;    // table holds no entry
		logic last;     // next entry to emit is the final one
		logic out_free; // result register can take a new line this cycle
	} dp_sts_t;

endpackage

FILE: rtl/tkri_ctrl.sv
// Controller for the ranking table: accept an item, then walk the table dump.
module tkri_ctrl
	import tkri_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t state_q;

	// Commands follow from the state and the handshake
	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.insert = item_valid;
			end
			ST_DUMP: begin
				cmd.emit = !sts.empty && sts.out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.insert) state_q <= ST_DUMP;
				end
				ST_DUMP: begin
					if (sts.empty || (cmd.emit && sts.last)) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/tkri_dp.sv
// Datapath for the ranking table: entry registers, parallel insert, rotating dump.
module tkri_dp
	import tkri_pkg::*;
#(
	parameter int RANK_DEPTH = 5,
	parameter int CNT_W      = $clog2(RANK_DEPTH + 1)
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    mode_wr_en,
	input  logic    mode_wr_data,
	input  item_t   item,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	input  logic    result_ready,
	output logic    result_valid,
	output result_t result
);

	// Stored record: key plus packed stamp
	typedef struct packed {
		logic signed [31:0] key;
		logic [11:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
	} entry_t;

	logic                 ascending_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 accepted_q;
	entry_t               entry_q [RANK_DEPTH];
	logic [RANK_DEPTH-1:0] hit;
	logic [RANK_DEPTH:0]   pre;
	logic                 item_ok;
	logic                 last_idx;
	entry_t               new_entry;
	result_t              result_q;
	logic                 result_valid_q;

	// Record validation: positive key, no zero stamp field
	assign item_ok = (item.entry_key > 32'sd0) && (item.stamp_year != '0) &&
		(item.stamp_month != '0) && (item.stamp_day != '0) &&
		(item.stamp_hour != '0) && (item.stamp_minute != '0);

	assign new_entry = '{key: item.entry_key, year: item.stamp_year,
		month: item.stamp_month, day: item.stamp_day,
		hour: item.stamp_hour, minute: item.stamp_minute};

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascending_q <= 1'b0;
		end else if (mode_wr_en) begin
			ascending_q <= mode_wr_data;
		end
	end

	// Per entry: does the new key strictly precede it, and is there an earlier hit
	assign pre[0] = 1'b0;

	for (genvar g = 0; g < RANK_DEPTH; g++) begin : g_entry
		localparam int PREV = (g == 0) ? 0 : g - 1;
		localparam int NEXT = (g == RANK_DEPTH - 1) ? g : g + 1;

		logic below;
		logic precedes;

		assign below    = CNT_W'(g) < count_q;
		assign precedes = ascending_q ? (item.entry_key < entry_q[g].key)
		                              : (item.entry_key > entry_q[g].key);
		assign hit[g]   = below && precedes;
		assign pre[g+1] = pre[g] | hit[g];

		// Insert shifts the tail down; a dump step rotates the valid entries up
		always_ff @(posedge clk) begin
			if (cmd.insert && item_ok) begin
				if (pre[g] && (g != 0)) begin
					entry_q[g] <= entry_q[PREV];
				end else if (hit[g] || (CNT_W'(g) == count_q)) begin
					entry_q[g] <= new_entry;
				end
			end else if (cmd.emit && below) begin
				if (CNT_W'(g) == count_q - CNT_W'(1)) begin
					entry_q[g] <= entry_q[0];
				end else begin
					entry_q[g] <= entry_q[NEXT];
				end
			end
		end
	end

	// Fill count, dump index and accepted flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			accepted_q <= 1'b0;
		end else if (cmd.insert) begin
			accepted_q <= item_ok;
			idx_q      <= '0;
			if (item_ok && (count_q != CNT_W'(RANK_DEPTH))) begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (cmd.emit) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	assign last_idx = (idx_q == count_q - CNT_W'(1));

	// Result register, loaded from the head of the rotating table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.rank_position  <= 3'(idx_q);
			result_q.ranked_key     <= entry_q[0].key;
			result_q.ranked_year    <= entry_q[0].year;
			result_q.ranked_month   <= entry_q[0].month;
			result_q.ranked_day     <= entry_q[0].day;
			result_q.ranked_hour    <= entry_q[0].hour;
			result_q.ranked_minute  <= entry_q[0].minute;
			result_q.input_accepted <= accepted_q;
			result_q.last_entry     <= last_idx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Status back to the controller
	assign sts.empty    = (count_q == '0);
	assign sts.last     = last_idx;
	assign sts.out_free = !result_valid_q || result_ready;

endmodule

FILE: rtl/top_k_ranking_insert.sv
// Top level of the top-K ranking table: controller, datapath and checks.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------
//   item     | item_valid / item_ready     | item (key and stamp)
//   result   | result_valid / result_ready | result (one ranked entry)
//   mode     | mode_wr_en, no wait         | mode_wr_data (1 = ascending)
//
// An item is checked and inserted against all entries at once, then the
// table is dumped one stored entry per cycle while the result register
// is free. A reject into an empty table still enters the dump state but
// emits no line.
// A stalled result holds the dump; the next item is taken while the last
// line of a dump still waits. Reset empties the table and sets descending.
module top_k_ranking_insert
	import tkri_pkg::*;
#(
	parameter int RANK_DEPTH = 5
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    mode_wr_en,
	input  logic    mode_wr_data,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tkri_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tkri_dp #(
		.RANK_DEPTH (RANK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_wr_en   (mode_wr_en),
		.mode_wr_data (mode_wr_data),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef SYNTHESIS
	// After an item transfer the block is busy with its dump
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item taken again right after a transfer");

	// A line is only loaded when the result register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwritten before transfer");

	// Nothing is dumped from an empty table
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.empty)
		else $error("dump from an empty table");

	// Insert and dump never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && cmd.insert))
		else $error("insert during dump");
`endif

endmodule
